// ===== hw/rtl/ssir_pkg.sv =====
// Shared types, sizes and codes for the sorted set store.
// Used by ssir_ctrl and sorted_set_insert_remove; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssir_pkg;

  // Store geometry
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Word field widths
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // One result word
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } result_t;

  // One cycle of memory access from the sequencer
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_set_insert_remove.sv =====
// The result reaches out_tvalid through the done state and the output register; on a non-empty store
// the sequencer first walks the entry RAM, one read and one write a cycle.
// The next word is taken while the result waits in the output register; a stalled output holds
// the following result in the sequencer, which takes no input until it is passed on.
// Reset (rst_n low, synchronous) empties the set; the entry RAM is not cleared.
// Top level of the sorted set store; uses ssir_pkg, ssir_ctrl and ssir_ram.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert_remove (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [0:0]  in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [2:0] status, [7:3] element_count
);

  import ssir_pkg::*;

  logic              res_valid;
  result_t           res;
  mem_req_t          mem_req;
  logic [VAL_W-1:0]  mem_rdata;
  logic              out_free;
  logic              out_valid_r;
  result_t           out_data_r;

  assign out_free = !out_valid_r || out_tready;

  ssir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_value  (in_tdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  ssir_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk   (clk),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ssir_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssir_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ssir_ctrl.sv =====
// Sequencer for the sorted set store: scans the entry RAM, inserts or removes
// by shifting entries one per cycle, and tracks the element count. Uses ssir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssir_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_op,
  input  wire logic [ssir_pkg::VAL_W-1:0]   in_value,
  input  wire logic                         out_free,
  output logic                              res_valid,
  output ssir_pkg::result_t                 res,
  output ssir_pkg::mem_req_t                mem_req,
  input  wire logic [ssir_pkg::VAL_W-1:0]   mem_rdata
);

  import ssir_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [VAL_W-1:0]    carry_r, carry_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic more;
  logic full;
  logic lt;
  logic eq;

  // Entry after the current one is still inside the set
  assign more = (CNT_W'(idx_r) + CNT_W'(1)) < count_r;
  assign full = (count_r == CNT_W'(CAPACITY));
  assign lt   = $signed(mem_rdata) < $signed(val_r);
  assign eq   = (mem_rdata == val_r);

  // Next state and memory access
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    carry_nxt  = carry_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    mem_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_op;
          val_nxt = in_value;
          idx_nxt = '0;
          if (count_r == '0) begin
            // Empty store: answer at once
            if (in_op == OP_ADD) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = '0;
              mem_req.wdata = in_value;
              count_nxt     = CNT_W'(1);
              status_nxt    = ST_ADDED;
            end else begin
              status_nxt = ST_ABSENT;
            end
            state_nxt = S_DONE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = '0;
            state_nxt     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (lt) begin
          if (more) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_r + ADDR_W'(1);
            idx_nxt       = idx_r + ADDR_W'(1);
          end else begin
            // Value belongs past the last entry
            if (op_r == OP_REMOVE) begin
              status_nxt = ST_ABSENT;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ADDR_W'(count_r);
              mem_req.wdata = val_r;
              count_nxt     = count_r + CNT_W'(1);
              status_nxt    = ST_ADDED;
            end
            state_nxt = S_DONE;
          end
        end else if (eq) begin
          if (op_r == OP_ADD) begin
            status_nxt = ST_PRESENT;
            state_nxt  = S_DONE;
          end else if (more) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_r + ADDR_W'(1);
            idx_nxt       = idx_r + ADDR_W'(1);
            state_nxt     = S_SHIFT;
          end else begin
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = ST_REMOVED;
            state_nxt  = S_DONE;
          end
        end else begin
          // First entry above the value: insertion point
          if (op_r == OP_REMOVE) begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_DONE;
          end else if (full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_r;
            mem_req.wdata = val_r;
            carry_nxt     = mem_rdata;
            if (more) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = idx_r + ADDR_W'(1);
              idx_nxt       = idx_r + ADDR_W'(1);
              state_nxt     = S_INS;
            end else begin
              state_nxt = S_TAIL;
            end
          end
        end
      end

      S_INS: begin
        // Move the carried entry up one place
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = carry_r;
        carry_nxt     = mem_rdata;
        if (more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r + ADDR_W'(1);
          idx_nxt       = idx_r + ADDR_W'(1);
        end else begin
          state_nxt = S_TAIL;
        end
      end

      S_TAIL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(count_r);
        mem_req.wdata = carry_r;
        count_nxt     = count_r + CNT_W'(1);
        status_nxt    = ST_ADDED;
        state_nxt     = S_DONE;
      end

      S_SHIFT: begin
        // Close the gap: move the entry down one place
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r - ADDR_W'(1);
        mem_req.wdata = mem_rdata;
        if (more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r + ADDR_W'(1);
          idx_nxt       = idx_r + ADDR_W'(1);
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = ST_REMOVED;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.count  = COUNT_W'(count_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    carry_r  <= carry_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

`ifndef SYNTHESIS
  // Reads always run ahead of writes, so one entry is never read and written together
  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.re && mem_req.we) |-> (mem_req.raddr != mem_req.waddr))
    else $error("read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((count_r == $past(count_r)) ||
                      (count_r == $past(count_r) + 1'b1) ||
                      (count_r + 1'b1 == $past(count_r))))
    else $error("element count moved by more than one");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r == S_DONE && out_free))
    else $error("result issued outside the done state");
`endif

endmodule

`default_nettype wire
